[rtl/tsc_pkg.sv]
// Shared types and fixed-point constants of the Taylor sine/cosine pipeline.
package tsc_pkg;

    localparam int ORD_W  = 6;
    localparam int ANG_W  = 32;
    localparam int VAL_W  = 32;
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    localparam logic [WORD_W-1:0] ONE_Q56 = WORD_W'(1) << 56;

    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    typedef struct packed {
        logic                     cos;
        logic [ORD_W-1:0]         ord;
        logic [WORD_W-1:0]        x2;
        logic signed [WORD_W-1:0] term;
        logic signed [WORD_W-1:0] acc;
    } t_item;

endpackage

[rtl/taylor_sine_cosine.sv]
// Top level of the pipelined Taylor series sine/cosine unit.
// Input channel: i_in_valid/o_in_ready with i_command (0 sine, 1 cosine)
//   and i_angle in signed Q3.29 radians; keep |angle| within pi.
// Output channel: o_out_valid/i_out_ready with o_value (signed Q2.30)
//   and o_saturated, set when the sum was clamped to the Q2.30 range.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_max_order, the
//   highest power in the series (clamped to MAX_ORDER); write while idle.
// Throughput: one beat per cycle while the receiver does not stall. Each
//   term step holds a coefficient multiply and a term multiply, each
//   split into two 32-bit stages.
// Reset clears all valid bits and sets max_order to 40.
// When the receiver stalls, the whole pipeline holds in place and
//   o_in_ready drops; nothing is lost or repeated.
module taylor_sine_cosine
    import tsc_pkg::*;
#(
    parameter int MAX_ORDER = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_command,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_saturated,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ORD_W-1:0]        i_cfg_max_order
);

    localparam int NSTEP = MAX_ORDER / 2;

    logic [ORD_W-1:0]   r_max_order;
    logic               w_en;
    logic [ANG_W-1:0]   w_ux;
    logic [WORD_W-1:0]  w_x2q58, w_x56m;
    logic signed [WORD_W-1:0] w_x56;
    logic [ORD_W-1:0]   w_ord;
    t_item              n_front, r_front;
    logic               r_front_vld;
    t_item              w_item [NSTEP+1];
    logic               w_vld  [NSTEP+1];

    t_item              w_last;
    logic               w_neg;
    logic [WORD_W-1:0]  w_am, w_a30;
    logic signed [VAL_W-1:0] n_value;
    logic               n_sat;
    logic signed [VAL_W-1:0] r_value;
    logic               r_sat, r_out_valid;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_order <= ORD_W'(40);
        end else if (i_cfg_valid) begin
            r_max_order <= i_cfg_max_order;
        end
    end

    always_comb begin
        w_ux    = i_angle[ANG_W-1] ? (ANG_W'(0) - i_angle) : i_angle;
        w_x2q58 = WORD_W'(w_ux) * WORD_W'(w_ux);
        w_x56m  = WORD_W'(w_ux) << 27;
        w_x56   = i_angle[ANG_W-1] ? (WORD_W'(0) - w_x56m) : w_x56m;
        w_ord   = (7'(r_max_order) > 7'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_max_order;
        n_front.cos = i_command;
        n_front.ord = w_ord;
        n_front.x2  = (w_x2q58 + WORD_W'(2)) >> 2;
        if (i_command == CMD_COSINE) begin
            n_front.term = ONE_Q56;
            n_front.acc  = ONE_Q56;
        end else begin
            n_front.term = w_x56;
            n_front.acc  = (w_ord >= ORD_W'(1)) ? w_x56 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
        end else if (w_en) begin
            r_front_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    assign w_item[0] = r_front;
    assign w_vld[0]  = r_front_vld;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        tsc_step #(.K(k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[k]),
            .i_item  (w_item[k]),
            .o_vld   (w_vld[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    always_comb begin
        w_last = w_item[NSTEP];
        w_neg  = w_last.acc[WORD_W-1];
        w_am   = w_neg ? (WORD_W'(0) - w_last.acc) : w_last.acc;
        w_a30  = (w_am + (WORD_W'(1) << 25)) >> 26;
        n_sat  = 1'b0;
        if (!w_neg && (w_a30 > WORD_W'(64'h7FFF_FFFF))) begin
            n_value = 32'sh7FFF_FFFF;
            n_sat   = 1'b1;
        end else if (w_neg && (w_a30 > WORD_W'(64'h8000_0000))) begin
            n_value = 32'sh8000_0000;
            n_sat   = 1'b1;
        end else begin
            n_value = w_neg ? (VAL_W'(0) - w_a30[VAL_W-1:0]) : w_a30[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule

[rtl/tsc_mulsh.sv]
// Two-stage unsigned 64x64 multiply with a rounded right shift.
module tsc_mulsh
    import tsc_pkg::*;
#(
    parameter int SHIFT = 56
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_p
);

    logic [WORD_W-1:0]   r_p0, r_p1, r_p2, r_p3;
    logic [2*WORD_W-1:0] n_full;
    logic [WORD_W-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= WORD_W'(i_a[HALF_W-1:0]) * WORD_W'(i_b[HALF_W-1:0]);
            r_p1 <= WORD_W'(i_a[WORD_W-1:HALF_W]) * WORD_W'(i_b[HALF_W-1:0]);
            r_p2 <= WORD_W'(i_a[HALF_W-1:0]) * WORD_W'(i_b[WORD_W-1:HALF_W]);
            r_p3 <= WORD_W'(i_a[WORD_W-1:HALF_W]) * WORD_W'(i_b[WORD_W-1:HALF_W]);
        end
    end

    always_comb begin
        n_full = {r_p3, r_p0}
               + ((2*WORD_W)'(r_p1) << HALF_W)
               + ((2*WORD_W)'(r_p2) << HALF_W)
               + ((2*WORD_W)'(1) << (SHIFT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_full[SHIFT +: WORD_W];
        end
    end

    assign o_p = r_p;

endmodule

[rtl/tsc_step.sv]
// One series term update: coefficient, term product and accumulate.
module tsc_step
    import tsc_pkg::*;
#(
    parameter int K = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    localparam int          NC = 2 + 2 * K;
    localparam int          NS = 3 + 2 * K;
    localparam longint unsigned DC = longint'(NC) * longint'(NC - 1);
    localparam longint unsigned DS = longint'(NS) * longint'(NS - 1);
    localparam logic [WORD_W-1:0] RC = WORD_W'(((64'd1 << 62) + DC / 2) / DC);
    localparam logic [WORD_W-1:0] RS = WORD_W'(((64'd1 << 62) + DS / 2) / DS);

    t_item             r_d1, r_d2, r_d3, r_d4, r_o;
    logic [4:0]        r_vld;
    logic [WORD_W-1:0] w_c, w_m, w_mag;
    logic [7:0]        w_n;
    logic              w_act;
    t_item             n_o;

    tsc_mulsh #(.SHIFT(62)) u_coef (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_item.x2),
        .i_b   ((i_item.cos == CMD_COSINE) ? RC : RS),
        .o_p   (w_c)
    );

    assign w_mag = r_d2.term[WORD_W-1] ? (WORD_W'(0) - r_d2.term) : r_d2.term;

    tsc_mulsh #(.SHIFT(56)) u_term (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_mag),
        .i_b   (w_c),
        .o_p   (w_m)
    );

    always_comb begin
        w_n   = (r_d4.cos == CMD_COSINE) ? 8'(NC) : 8'(NS);
        w_act = w_n <= 8'(r_d4.ord);
        n_o   = r_d4;
        if (w_act) begin
            n_o.term = r_d4.term[WORD_W-1] ? w_m : (WORD_W'(0) - w_m);
            n_o.acc  = r_d4.acc + n_o.term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1 <= i_item;
            r_d2 <= r_d1;
            r_d3 <= r_d2;
            r_d4 <= r_d3;
            r_o  <= n_o;
        end
    end

    assign o_vld  = r_vld[4];
    assign o_item = r_o;

endmodule
